[hdl/activity_counter_freq_scale_unit_defines.svh]
// Assertion macros for the checker file of the frequency scale unit.
// No dependencies; include by bare file name.
`ifndef ACTIVITY_COUNTER_FREQ_SCALE_UNIT_DEFINES_SVH
`define ACTIVITY_COUNTER_FREQ_SCALE_UNIT_DEFINES_SVH

// Clocked assertion that is switched off while reset is high.
`define ACFS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ACFS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/acfs_pkg.sv]
// Package for the activity counter frequency scale unit: widths, register
// indexes and the controller/datapath command and status types. No dependencies.
package acfs_pkg;

   localparam int COUNT_W        = 64;
   localparam int RATIO_W        = 32;
   localparam int HALF_W         = COUNT_W / 2;
   localparam int SCALE_W        = 11;
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = 32;
   localparam int CAPACITY_SHIFT = 10;
   localparam int DIV_CNT_W      = $clog2(COUNT_W);

   // Full capacity, the saturation point of the quotient.
   localparam logic [COUNT_W-1:0] CAP_FULL = COUNT_W'(1) << CAPACITY_SHIFT;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE         = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_FREQ_RATIO = CSR_INDEX_W'(1);

   // Operation codes of a request.
   localparam logic OP_SET_REF = 1'b0;
   localparam logic OP_TICK    = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic check;
      logic mul_lo;
      logic mul_hi;
      logic sum;
      logic div_step;
      logic out_load;
   } acfs_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic compute;
   } acfs_status_type;

endpackage

[hdl/acfs_datapath.sv]
// Datapath of the frequency scale unit: configuration and reference registers,
// delta check, split 64x32 multiply, bit-serial divider and result register.
// Depends on acfs_pkg.
module acfs_datapath
   import acfs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  acfs_cmd_type           cmd,
   output acfs_status_type        status,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_operation,
   input  logic [COUNT_W-1:0]     req_core_count,
   input  logic [COUNT_W-1:0]     req_const_count,
   output logic [SCALE_W-1:0]     rsp_scale,
   output logic                   rsp_scale_written
);

   logic                 enable_ff, enable_in;
   logic [RATIO_W-1:0]   ratio_ff, ratio_in;
   logic [COUNT_W-1:0]   last_core_ff, last_core_in;
   logic [COUNT_W-1:0]   last_const_ff, last_const_in;

   logic                 op_ff;
   logic [COUNT_W-1:0]   core_ff;
   logic [COUNT_W-1:0]   const_ff;
   logic [COUNT_W-1:0]   core_delta_ff;
   logic [COUNT_W-1:0]   const_delta_ff;
   logic                 written_ff;
   logic [COUNT_W-1:0]   prod_lo_ff;
   logic [HALF_W-1:0]    prod_hi_ff;
   logic [COUNT_W-1:0]   rem_ff, rem_in;
   logic [COUNT_W-1:0]   quo_ff, quo_in;
   logic [SCALE_W-1:0]   scale_ff;
   logic                 scale_written_ff;

   logic [COUNT_W:0]     core_diff;
   logic [COUNT_W:0]     const_diff;
   logic                 core_adv;
   logic                 const_adv;
   logic [COUNT_W-1:0]   prod_hi_full;
   logic [COUNT_W-1:0]   product;
   logic [COUNT_W:0]     div_shifted;
   logic [COUNT_W+1:0]   div_trial;
   logic                 div_ge;
   logic [COUNT_W-1:0]   quo_sat;

   // Advance check: a counter advanced when the difference has no borrow and is nonzero.
   assign core_diff  = {1'b0, core_ff} - {1'b0, last_core_ff};
   assign const_diff = {1'b0, const_ff} - {1'b0, last_const_ff};
   assign core_adv   = !core_diff[COUNT_W] && (core_diff[COUNT_W-1:0] != '0);
   assign const_adv  = !const_diff[COUNT_W] && (const_diff[COUNT_W-1:0] != '0);
   assign status.compute = (op_ff == OP_TICK) && enable_ff && core_adv && const_adv;

   // Configuration writes and reference updates.
   always_comb begin
      enable_in     = enable_ff;
      ratio_in      = ratio_ff;
      last_core_in  = last_core_ff;
      last_const_in = last_const_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_ENABLE:         enable_in = csr_wdata[0];
            CSR_MAX_FREQ_RATIO: ratio_in  = csr_wdata[RATIO_W-1:0];
            default: ;
         endcase
      end
      // A disabled tick leaves the references alone.
      if (cmd.check && ((op_ff == OP_SET_REF) || enable_ff)) begin
         last_core_in  = core_ff;
         last_const_in = const_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff     <= 1'b0;
         ratio_ff      <= '0;
         last_core_ff  <= '0;
         last_const_ff <= '0;
      end else begin
         enable_ff     <= enable_in;
         ratio_ff      <= ratio_in;
         last_core_ff  <= last_core_in;
         last_const_ff <= last_const_in;
      end
   end

   // Upper partial product only contributes its low half to the 64-bit wrap.
   assign prod_hi_full = core_delta_ff[COUNT_W-1:HALF_W] * ratio_ff;
   assign product      = prod_lo_ff + {prod_hi_ff, HALF_W'(0)};

   // One restoring division step: shift in the next dividend bit and trial subtract.
   assign div_shifted = {rem_ff, quo_ff[COUNT_W-1]};
   assign div_trial   = {1'b0, div_shifted} - {2'b00, const_delta_ff};
   assign div_ge      = !div_trial[COUNT_W+1];

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (cmd.sum) begin
         rem_in = '0;
         quo_in = product >> CAPACITY_SHIFT;
      end else if (cmd.div_step) begin
         rem_in = div_ge ? div_trial[COUNT_W-1:0] : div_shifted[COUNT_W-1:0];
         quo_in = {quo_ff[COUNT_W-2:0], div_ge};
      end
   end

   // Saturate the quotient to full capacity.
   assign quo_sat = (quo_ff >= CAP_FULL) ? CAP_FULL : quo_ff;

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_operation;
         core_ff  <= req_core_count;
         const_ff <= req_const_count;
      end
      if (cmd.check) begin
         core_delta_ff  <= core_diff[COUNT_W-1:0];
         const_delta_ff <= const_diff[COUNT_W-1:0];
         written_ff     <= status.compute;
      end
      if (cmd.mul_lo) begin
         prod_lo_ff <= core_delta_ff[HALF_W-1:0] * ratio_ff;
      end
      if (cmd.mul_hi) begin
         prod_hi_ff <= prod_hi_full[HALF_W-1:0];
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (cmd.out_load) begin
         scale_ff         <= written_ff ? quo_sat[SCALE_W-1:0] : '0;
         scale_written_ff <= written_ff;
      end
   end

   assign rsp_scale         = scale_ff;
   assign rsp_scale_written = scale_written_ff;

endmodule

[hdl/acfs_ctrl.sv]
// Controller of the frequency scale unit: sequences check, multiply, divide
// and result hand-off, and owns both handshakes. Depends on acfs_pkg.
module acfs_ctrl
   import acfs_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output acfs_cmd_type    cmd,
   input  acfs_status_type status
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_MUL_LO,
      S_MUL_HI,
      S_SUM,
      S_DIV,
      S_DONE
   } state_type;

   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(COUNT_W - 1);

   state_type            state_ff, state_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Next state and datapath commands.
   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
            if (req_valid) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = status.compute ? S_MUL_LO : S_DONE;
         end
         S_MUL_LO: begin
            cmd.mul_lo = 1'b1;
            state_in   = S_MUL_HI;
         end
         S_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = S_SUM;
         end
         S_SUM: begin
            cmd.sum    = 1'b1;
            div_cnt_in = '0;
            state_in   = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + DIV_CNT_W'(1);
            if (div_cnt_ff == DIV_LAST) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // Hand the result over once the output register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // The output register stays valid until the response is taken.
   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[hdl/activity_counter_freq_scale_unit.sv]
// Top level of the activity counter frequency scale unit: joins the controller
// and the datapath. Depends on acfs_pkg, acfs_ctrl and acfs_datapath.
//
//   Channel   Direction  Handshake               Payload
//   req_      in         req_valid / req_ready   req_operation, req_core_count,
//                                                req_const_count
//   rsp_      out        rsp_valid / rsp_ready   rsp_scale, rsp_scale_written
//   csr_      in         csr_write_en            csr_index, csr_wdata
//
// A tick that produces a scale runs a check, the low and high multiply steps, a sum,
// the bit-serial divider steps and a hand-off, which waits for a free output register.
// The next request is taken once the result is loaded. Other requests go from the
// check straight to the hand-off.
// Synchronous reset clears the configuration, the references and the control.
// A new request is accepted while a finished response waits on rsp_ready; the
// next result then holds in the datapath until the output register frees.
module activity_counter_freq_scale_unit
   import acfs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_operation,
   input  logic [COUNT_W-1:0]     req_core_count,
   input  logic [COUNT_W-1:0]     req_const_count,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [SCALE_W-1:0]     rsp_scale,
   output logic                   rsp_scale_written,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   acfs_cmd_type    cmd;
   acfs_status_type status;

   // Sequencer.
   acfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // Arithmetic and state.
   acfs_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_operation     (req_operation),
      .req_core_count    (req_core_count),
      .req_const_count   (req_const_count),
      .rsp_scale         (rsp_scale),
      .rsp_scale_written (rsp_scale_written)
   );

endmodule

[hdl/acfs_checker.sv]
// Port-level checker of the activity counter frequency scale unit and its bind.
// Depends on acfs_pkg and activity_counter_freq_scale_unit_defines.svh.
`include "activity_counter_freq_scale_unit_defines.svh"

module acfs_checker
   import acfs_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [SCALE_W-1:0] rsp_scale,
   input logic               rsp_scale_written
);

   localparam logic [SCALE_W-1:0] SCALE_MAX = CAP_FULL[SCALE_W-1:0];
   localparam logic               CAP_FITS  = CAPACITY_SHIFT < SCALE_W;

   // A response without a new scale reports zero.
   `ACFS_ASSERT(a_unwritten_zero, clock, reset, (rsp_valid && !rsp_scale_written) |-> (rsp_scale == '0), "unwritten response carries nonzero scale")

   // A reported scale never exceeds full capacity.
   `ACFS_ASSERT(a_scale_saturated, clock, reset, (rsp_valid && CAP_FITS) |-> (rsp_scale <= SCALE_MAX), "scale above full capacity")

   // The unit works on one request at a time.
   `ACFS_ASSERT(a_busy_after_accept, clock, reset, (req_valid && req_ready) |=> !req_ready, "request accepted while busy")

   // A response stays offered until it is taken.
   `ACFS_ASSERT(a_rsp_held, clock, reset, (rsp_valid && !rsp_ready) |=> rsp_valid, "response dropped before acceptance")

   // Reset leaves no response pending.
   `ACFS_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid, "response valid after reset")

endmodule

bind activity_counter_freq_scale_unit acfs_checker u_acfs_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_scale         (rsp_scale),
   .rsp_scale_written (rsp_scale_written)
);

[sim/tb.sv]
// Self-checking testbench for activity_counter_freq_scale_unit, with a small scoreboard
// class that predicts the frequency scale from the counter snapshots.
// Depends on acfs_pkg and the RTL of the unit.
`timescale 1ns / 1ps

module tb;
   import acfs_pkg::*;

   localparam int NUM_PHASES      = 10;
   localparam int ITEMS_PER_PHASE = 170;
   localparam int MAX_REPORTS     = 10;
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int DRAIN_CYCLES    = 80;

   // Register indexes that select no register.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_2 = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_3 = CSR_INDEX_W'(3);

   localparam logic [COUNT_W-1:0] ALL_ONES = {COUNT_W{1'b1}};

   typedef struct packed {
      logic [SCALE_W-1:0] scale;
      logic               written;
   } freq_result_type;

   // Tracks the unit's configuration and reference counters and holds the
   // responses that are still owed, oldest first.
   class freq_scale_board;
      logic                 enabled;
      logic [RATIO_W-1:0]   ratio;
      logic [COUNT_W-1:0]   ref_core;
      logic [COUNT_W-1:0]   ref_const;
      freq_result_type      owed_scales[$];
      int                   errors;
      int                   requests;
      int                   scales_made;
      int                   saturated;

      function new();
         enabled     = 1'b0;
         ratio       = '0;
         ref_core    = '0;
         ref_const   = '0;
         errors      = 0;
         requests    = 0;
         scales_made = 0;
         saturated   = 0;
      endfunction

      function void apply_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_ENABLE:         enabled = data[0];
            CSR_MAX_FREQ_RATIO: ratio   = data[RATIO_W-1:0];
            default: ;
         endcase
      endfunction

      // Works out the response that an accepted request must produce.
      function void note_request(logic op, logic [COUNT_W-1:0] core, logic [COUNT_W-1:0] cnst);
         logic [COUNT_W-1:0] product;
         logic [COUNT_W-1:0] quotient;
         freq_result_type    result;
         result   = '0;
         requests++;
         if (op == OP_SET_REF) begin
            ref_core  = core;
            ref_const = cnst;
         end else if (enabled) begin
            if (core > ref_core && cnst > ref_const) begin
               product  = (core - ref_core) * {{(COUNT_W-RATIO_W){1'b0}}, ratio};
               quotient = (product >> CAPACITY_SHIFT) / (cnst - ref_const);
               if (quotient >= CAP_FULL) begin
                  quotient = CAP_FULL;
                  saturated++;
               end
               result.scale   = quotient[SCALE_W-1:0];
               result.written = 1'b1;
               scales_made++;
            end
            ref_core  = core;
            ref_const = cnst;
         end
         owed_scales.push_back(result);
      endfunction

      function void check_response(logic [SCALE_W-1:0] scale, logic written);
         freq_result_type want;
         if (owed_scales.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("ERROR: response scale=%0d written=%0d with no request outstanding",
                        scale, written);
         end else begin
            want = owed_scales.pop_front();
            if (want.scale !== scale || want.written !== written) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("ERROR: scale expected %0d got %0d, written expected %0d got %0d",
                           want.scale, scale, want.written, written);
            end
         end
      endfunction

      function int pending();
         return owed_scales.size();
      endfunction
   endclass

   logic                   clock;
   logic                   reset             = 1'b1;
   logic                   req_valid         = 1'b0;
   logic                   req_ready;
   logic                   req_operation     = 1'b0;
   logic [COUNT_W-1:0]     req_core_count    = '0;
   logic [COUNT_W-1:0]     req_const_count   = '0;
   logic                   rsp_valid;
   logic                   rsp_ready         = 1'b0;
   logic [SCALE_W-1:0]     rsp_scale;
   logic                   rsp_scale_written;
   logic                   csr_write_en      = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index         = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata         = '0;

   freq_scale_board sb;
   bit              idle_on = 1'b1;
   int              stall_left = 0;
   int              idle_cycles = 0;
   int              settings = 0;

   activity_counter_freq_scale_unit DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_core_count    (req_core_count),
      .req_const_count   (req_const_count),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_scale         (rsp_scale),
      .rsp_scale_written (rsp_scale_written),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Gap length between requests: mostly none or short, now and then long.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (!idle_on || roll < 45)
         return 0;
      else if (roll < 92)
         return $urandom_range(1, 4);
      else
         return $urandom_range(20, 150);
   endfunction

   // Response side: random stalls on rsp_ready, none while idling is off.
   always @(posedge clock) begin
      if (!idle_on) begin
         rsp_ready  <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 99) < 25) begin
         rsp_ready  <= 1'b0;
         stall_left <= ($urandom_range(0, 99) < 90) ? $urandom_range(0, 3)
                                                    : $urandom_range(20, 150);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Every accepted response is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_scale, rsp_scale_written);
   end

   // Watchdog: ends the run if nothing moves for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_en) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("ERROR: no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Drives one request, notes it when accepted, then leaves a random gap.
   task automatic send_request(input logic op, input logic [COUNT_W-1:0] core,
                               input logic [COUNT_W-1:0] cnst);
      int gap;
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_core_count  <= core;
      req_const_count <= cnst;
      do
         @(posedge clock);
      while (!req_ready);
      sb.note_request(op, core, cnst);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Register writes happen only once every owed response has come back.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= data;
      @(posedge clock);
      sb.apply_register(index, data);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly ticks whose deltas aim at a chosen scale; the rest overflow
   // products, counters that do not advance, new references and noise.
   task automatic random_request();
      int                 kind;
      int unsigned        target;
      logic [COUNT_W-1:0] dcore;
      logic [COUNT_W-1:0] dconst;
      logic [COUNT_W-1:0] core;
      logic [COUNT_W-1:0] cnst;
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
         target = $urandom_range(0, 1200);
         dconst = ($urandom_range(0, 3) == 0) ? COUNT_W'($urandom_range(1, 15))
                                              : COUNT_W'($urandom_range(1, 1 << 22));
         if (sb.ratio == '0)
            dcore = COUNT_W'($urandom_range(1, 1 << 30));
         else
            dcore = ((dconst * target) << CAPACITY_SHIFT) / sb.ratio
                    + COUNT_W'($urandom_range(0, 3));
         if (dcore == '0)
            dcore = COUNT_W'(1);
         send_request(OP_TICK, sb.ref_core + dcore, sb.ref_const + dconst);
      end else if (kind < 70) begin
         dcore  = {$urandom, $urandom} >> $urandom_range(0, 40);
         dconst = {$urandom, $urandom} >> $urandom_range(0, 63);
         send_request(OP_TICK, sb.ref_core + dcore, sb.ref_const + dconst);
      end else if (kind < 80) begin
         core = sb.ref_core - COUNT_W'($urandom_range(0, 2));
         cnst = sb.ref_const + COUNT_W'($urandom_range(1, 1000));
         if ($urandom_range(0, 1) == 0) begin
            core = sb.ref_core + COUNT_W'($urandom_range(1, 1 << 20));
            cnst = sb.ref_const - COUNT_W'($urandom_range(0, 2));
         end
         send_request(OP_TICK, core, cnst);
      end else if (kind < 88) begin
         send_request(OP_SET_REF, {$urandom, $urandom}, {$urandom, $urandom});
      end else begin
         send_request(1'($urandom_range(0, 1)), {$urandom, $urandom}, {$urandom, $urandom});
      end
   endtask

   // Register settings per phase, the extremes among them.
   function automatic logic [RATIO_W-1:0] phase_ratio(input int ph);
      case (ph)
         0:       return RATIO_W'(34952);
         1:       return RATIO_W'(32'h0010_0000);
         2:       return {RATIO_W{1'b1}};
         3:       return RATIO_W'(1);
         5:       return '0;
         9:       return RATIO_W'(32'h8000_0000);
         default: return RATIO_W'($urandom);
      endcase
   endfunction

   // Main sequence: reset, directed requests, then randomized phases.
   initial begin
      logic [CSR_DATA_W-1:0] junk;
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Ticks while disabled leave the references alone.
      send_request(OP_TICK, 64'd5, 64'd5);
      send_request(OP_SET_REF, ALL_ONES, ALL_ONES);
      send_request(OP_TICK, 64'd7, 64'd9);

      // Exact full scale, half scale, counters that do not advance,
      // saturation and a zero quotient.
      write_reg(CSR_ENABLE, 32'hFFFF_FFFF);
      write_reg(CSR_MAX_FREQ_RATIO, 32'h0010_0000);
      settings++;
      send_request(OP_SET_REF, 64'd0, 64'd0);
      send_request(OP_TICK, 64'd1000, 64'd1000);
      send_request(OP_TICK, 64'd1500, 64'd2000);
      send_request(OP_TICK, 64'd1500, 64'd3000);
      send_request(OP_TICK, 64'd2500, 64'd2999);
      send_request(OP_TICK, 64'd3524, 64'd4023);
      send_request(OP_TICK, 64'd3524 + (64'd1 << 40), 64'd4024);
      send_request(OP_TICK, 64'd3525 + (64'd1 << 40), 64'd4024 + (64'd1 << 40));

      // Largest ratio: the product wraps; a wrapped core counter gives no scale.
      write_reg(CSR_MAX_FREQ_RATIO, 32'hFFFF_FFFF);
      settings++;
      send_request(OP_SET_REF, 64'd0, 64'd0);
      send_request(OP_TICK, ALL_ONES, 64'd1);
      send_request(OP_TICK, 64'd0, 64'd2);
      send_request(OP_TICK, 64'd1 << 33, 64'd3);
      send_request(OP_TICK, (64'd1 << 33) + 64'd1000, ALL_ONES);

      // Disable, write the spare indexes, re-enable with junk in the upper bits.
      write_reg(CSR_ENABLE, 32'hFFFF_FFFE);
      send_request(OP_SET_REF, 64'd100, 64'd100);
      send_request(OP_TICK, 64'd50000, 64'd50000);
      write_reg(CSR_SPARE_2, 32'h0000_0000);
      write_reg(CSR_SPARE_3, 32'hFFFF_FFFF);
      write_reg(CSR_ENABLE, 32'hABCD_EF01);
      write_reg(CSR_MAX_FREQ_RATIO, 32'h0001_0000);
      settings++;
      send_request(OP_TICK, 64'd1100, 64'd200);
      send_request(OP_TICK, 64'd1100, 64'd300);

      // Randomized phases, one of them without any idling.
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         idle_on = (ph != 7);
         junk = $urandom;
         write_reg((ph % 2 == 0) ? CSR_SPARE_2 : CSR_SPARE_3, $urandom);
         write_reg(CSR_ENABLE, {junk[CSR_DATA_W-1:1], (ph != 4)});
         write_reg(CSR_MAX_FREQ_RATIO, phase_ratio(ph));
         settings++;
         repeat (ITEMS_PER_PHASE) random_request();
      end
      idle_on = 1'b1;

      // Drain the owed responses, then watch for stray ones.
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d requests over %0d register settings.", sb.requests, settings);
      $display("%0d ticks produced a scale, %0d of them saturated; %0d errors.",
               sb.scales_made, sb.saturated, sb.errors + sb.pending());
      if (sb.errors == 0 && sb.pending() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
